// ===== rtl/core/bpuck_pkg.sv =====
// Shared types, codes and helpers for the BMP pixel unpack / color-key / zoom block.
// No dependencies.
`default_nettype none

package bpuck_pkg;

    // Defaults for the top-level parameters
    localparam int DEF_PALETTE_ENTRIES = 256;
    localparam int DEF_MAX_WIDTH       = 4096;
    localparam int DEF_MAX_ZOOM        = 4;

    // Replication beyond 4 never happens: two pixels must fit in 32 writes
    localparam int ZOOM_LIMIT = 4;

    // Pixel job queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [3:0] NIBBLE_MASK = 4'hF;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PALETTE = 2'd1,
        OP_PIXEL   = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        FMT_4BPP  = 2'd0,
        FMT_8BPP  = 2'd1,
        FMT_24BPP = 2'd2,
        FMT_32BPP = 2'd3
    } t_fmt;

    typedef enum logic [1:0] {
        KEY_DRAW_ALL = 2'd0,
        KEY_SKIP     = 2'd1,
        KEY_SUBST    = 2'd2
    } t_key_mode;

    typedef enum logic [2:0] {
        REG_PIXEL_FORMAT     = 3'd0,
        REG_IMAGE_WIDTH      = 3'd1,
        REG_ORIGIN_X         = 3'd2,
        REG_BASE_Y           = 3'd3,
        REG_ZOOM_LEVEL       = 3'd4,
        REG_KEY_MODE         = 3'd5,
        REG_KEY_COLOR        = 3'd6,
        REG_SUBSTITUTE_COLOR = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [1:0]  pixel_format;
        logic [12:0] image_width;
        logic [9:0]  origin_x;
        logic [15:0] base_y;
        logic [2:0]  zoom_level;
        logic [1:0]  key_mode;
        logic [31:0] key_color;
        logic [31:0] substitute_color;
    } t_cfg;

    // One queued item: up to two decoded pixels with their base coordinates
    typedef struct packed {
        logic        draw_a;
        logic [31:0] color_a;
        logic [15:0] x_a;
        logic [15:0] y_a;
        logic        draw_b;
        logic [31:0] color_b;
        logic [15:0] x_b;
        logic [15:0] y_b;
    } t_pix_job;

    // Effective replication factor: 0 acts as 1, clamp at cap (cap <= 4)
    function automatic logic [2:0] eff_zoom(input logic [2:0] zoom, input int cap);
        logic [2:0] z;
        z = zoom;
        if (z == 3'd0) z = 3'd1;
        if (z > 3'(cap)) z = 3'(cap);
        return z;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bpuck_front.sv =====
// Front end: accepts input items, owns the palette memory and the image position,
// decodes bytes into pixels and applies the color key. Uses bpuck_pkg.
`default_nettype none

module bpuck_front import bpuck_pkg::*; #(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_ZOOM        = DEF_MAX_ZOOM
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_palette_slot,
    input  wire logic [31:0] i_palette_word,
    input  wire logic [7:0]  i_data_byte,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_pix_job         o_job
);

    localparam int PW       = $clog2(PALETTE_ENTRIES);
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int ZOOM_CAP = (MAX_ZOOM < ZOOM_LIMIT) ? MAX_ZOOM : ZOOM_LIMIT;

    // palette
    logic [31:0] r_pal [PALETTE_ENTRIES];
    logic [31:0] r_rd_a, r_rd_b;

    // image position and true-color assembly
    logic [CW-1:0] r_col;
    logic [15:0]   r_row;
    logic [1:0]    r_bphase;
    logic [23:0]   r_partial;

    logic [CW-1:0] n_col;
    logic [15:0]   n_row;
    logic [1:0]    n_bphase;
    logic [23:0]   n_partial;

    // decode stage
    logic          r_s1_valid;
    logic          r_s1_va, r_s1_vb, r_s1_direct, r_s1_oor_a, r_s1_oor_b;
    logic [23:0]   r_s1_dcolor;
    logic [CW-1:0] r_s1_col_a, r_s1_col_b;
    logic [15:0]   r_s1_row_a, r_s1_row_b;

    logic          accept, acc_data, acc_pal, slot_oor;
    logic [CW:0]   eff_w, colp1, colp2;
    logic [CW-1:0] col1, col2;
    logic [15:0]   row1, row2;
    logic          va, vb, direct;
    logic [23:0]   dcolor;
    logic [7:0]    idx_a, idx_b;
    logic [1:0]    bpe;
    logic [16:0]   w_full;
    logic [2:0]    zoom;

    function automatic logic [23:0] lane(input logic [7:0] b, input logic [1:0] p);
        logic [23:0] v;
        case (p)
            2'd0:    v = {16'h0000, b};
            2'd1:    v = {8'h00, b, 8'h00};
            default: v = {b, 16'h0000};
        endcase
        return v;
    endfunction

    assign o_stall  = r_s1_valid && i_q_full;
    assign accept   = i_valid && !o_stall;
    assign acc_data = accept && (i_opcode == OP_PIXEL);
    assign acc_pal  = accept && (i_opcode == OP_PALETTE);
    assign slot_oor = {1'b0, i_palette_slot} >= 9'(PALETTE_ENTRIES);
    assign zoom     = eff_zoom(i_cfg.zoom_level, ZOOM_CAP);

    // effective width: zero acts as one, clamp at MAX_WIDTH
    always_comb begin
        w_full = {4'h0, i_cfg.image_width};
        if (w_full == 17'd0) w_full = 17'd1;
        if (w_full > 17'(MAX_WIDTH)) w_full = 17'(MAX_WIDTH);
        eff_w = w_full[CW:0];
    end

    // position after one and after two pixels
    always_comb begin
        colp1 = {1'b0, r_col} + (CW+1)'(1);
        col1  = (colp1 >= eff_w) ? '0 : colp1[CW-1:0];
        row1  = (colp1 >= eff_w) ? r_row + 16'd1 : r_row;
        colp2 = {1'b0, col1} + (CW+1)'(1);
        col2  = (colp2 >= eff_w) ? '0 : colp2[CW-1:0];
        row2  = (colp2 >= eff_w) ? row1 + 16'd1 : row1;
    end

    // byte decode per pixel format
    always_comb begin
        va        = 1'b0;
        vb        = 1'b0;
        direct    = 1'b0;
        dcolor    = r_partial;
        idx_a     = i_data_byte;
        idx_b     = {4'h0, i_data_byte[3:0] & NIBBLE_MASK};
        n_col     = r_col;
        n_row     = r_row;
        n_bphase  = r_bphase;
        n_partial = r_partial;
        bpe       = (r_bphase > 2'd2) ? 2'd0 : r_bphase;
        case (t_fmt'(i_cfg.pixel_format))
            FMT_4BPP: begin
                va    = 1'b1;
                vb    = 1'b1;
                idx_a = {4'h0, i_data_byte[7:4] & NIBBLE_MASK};
                n_col = col2;
                n_row = row2;
            end
            FMT_8BPP: begin
                va    = 1'b1;
                n_col = col1;
                n_row = row1;
            end
            FMT_24BPP: begin
                dcolor = r_partial | lane(i_data_byte, bpe);
                if (bpe == 2'd2) begin
                    va        = 1'b1;
                    direct    = 1'b1;
                    n_bphase  = 2'd0;
                    n_partial = '0;
                    n_col     = col1;
                    n_row     = row1;
                end else begin
                    n_bphase  = bpe + 2'd1;
                    n_partial = dcolor;
                end
            end
            default: begin
                // 32 bpp: alpha byte closes the pixel and is dropped
                if (r_bphase == 2'd3) begin
                    va        = 1'b1;
                    direct    = 1'b1;
                    n_bphase  = 2'd0;
                    n_partial = '0;
                    n_col     = col1;
                    n_row     = row1;
                end else begin
                    n_bphase  = r_bphase + 2'd1;
                    n_partial = r_partial | lane(i_data_byte, r_bphase);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc_pal && !slot_oor) begin
            r_pal[i_palette_slot[PW-1:0]] <= i_palette_word;
        end
        if (acc_data) begin
            r_rd_a <= r_pal[idx_a[PW-1:0]];
            r_rd_b <= r_pal[idx_b[PW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_bphase  <= '0;
            r_partial <= '0;
        end else if (accept && i_opcode == OP_START) begin
            r_col     <= '0;
            r_row     <= '0;
            r_bphase  <= '0;
            r_partial <= '0;
        end else if (acc_data) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_bphase  <= n_bphase;
            r_partial <= n_partial;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= acc_data && va;
        end else if (!i_q_full) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_data) begin
            r_s1_va     <= va;
            r_s1_vb     <= vb;
            r_s1_direct <= direct;
            r_s1_dcolor <= dcolor;
            r_s1_oor_a  <= {1'b0, idx_a} >= 9'(PALETTE_ENTRIES);
            r_s1_oor_b  <= {1'b0, idx_b} >= 9'(PALETTE_ENTRIES);
            r_s1_col_a  <= r_col;
            r_s1_row_a  <= r_row;
            r_s1_col_b  <= col1;
            r_s1_row_b  <= row1;
        end
    end

    // key filter and base coordinates
    logic [31:0] color_a, color_b;
    logic        key_a, key_b;

    always_comb begin
        color_a = r_s1_direct ? {8'h00, r_s1_dcolor} : (r_s1_oor_a ? 32'h0 : r_rd_a);
        color_b = r_s1_oor_b ? 32'h0 : r_rd_b;
        key_a   = color_a == i_cfg.key_color;
        key_b   = color_b == i_cfg.key_color;

        o_job.draw_a  = r_s1_va && !(i_cfg.key_mode == KEY_SKIP && key_a);
        o_job.draw_b  = r_s1_vb && !(i_cfg.key_mode == KEY_SKIP && key_b);
        o_job.color_a = (i_cfg.key_mode == KEY_SUBST && key_a) ? i_cfg.substitute_color
                                                                 : color_a;
        o_job.color_b = (i_cfg.key_mode == KEY_SUBST && key_b) ? i_cfg.substitute_color
                                                                 : color_b;
        o_job.x_a = {6'h00, i_cfg.origin_x} + 16'(r_s1_col_a) * {13'h0, zoom};
        o_job.x_b = {6'h00, i_cfg.origin_x} + 16'(r_s1_col_b) * {13'h0, zoom};
        o_job.y_a = i_cfg.base_y - r_s1_row_a * {13'h0, zoom};
        o_job.y_b = i_cfg.base_y - r_s1_row_b * {13'h0, zoom};
    end

    assign o_push = r_s1_valid && !i_q_full && (o_job.draw_a || o_job.draw_b);

endmodule

`default_nettype wire

// ===== rtl/core/bpuck_queue.sv =====
// Short job queue between the decode front end and the write back end.
// Uses bpuck_pkg for the job type and depth.
`default_nettype none

module bpuck_queue import bpuck_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_pix_job i_job,
    input  wire logic     i_pop,
    output logic          o_full,
    output logic          o_empty,
    output t_pix_job      o_head
);

    t_pix_job        r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_AW:0]   r_count;

    assign o_full  = r_count == (Q_AW+1)'(Q_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + Q_AW'(1);
            if (i_pop)  r_rd <= r_rd + Q_AW'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (Q_AW+1)'(1);
                2'b01:   r_count <= r_count - (Q_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("job queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("job queue underflow");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("job queue count out of range");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bpuck_back.sv =====
// Back end: expands each queued pixel that is to be drawn into zoom x zoom backbuffer
// writes and drives the registered output channel. Uses bpuck_pkg.
`default_nettype none

module bpuck_back import bpuck_pkg::*; #(
    parameter int MAX_ZOOM = DEF_MAX_ZOOM
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_empty,
    input  wire t_pix_job    i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_pixel_x,
    output logic [15:0]      o_pixel_y,
    output logic [31:0]      o_pixel_color,
    output logic             o_last_write
);

    localparam int ZOOM_CAP = (MAX_ZOOM < ZOOM_LIMIT) ? MAX_ZOOM : ZOOM_LIMIT;

    logic       r_valid;
    logic [1:0] r_dx, r_dy;
    logic       r_sel;

    logic       load, sel_b, pix_end, last;
    logic [1:0] zm1;
    logic [2:0] zoom;

    assign zoom    = eff_zoom(i_cfg.zoom_level, ZOOM_CAP);
    assign zm1     = 2'(zoom - 3'd1);
    assign load    = !i_empty && (!r_valid || !i_stall);
    assign sel_b   = r_sel || !i_job.draw_a;
    assign pix_end = (r_dx == zm1) && (r_dy == zm1);
    assign last    = pix_end && (sel_b || !i_job.draw_b);
    assign o_pop   = load && last;
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_sel   <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
            if (load) begin
                if (pix_end) begin
                    r_dx  <= '0;
                    r_dy  <= '0;
                    r_sel <= !last;
                end else if (r_dx == zm1) begin
                    r_dx <= '0;
                    r_dy <= r_dy + 2'd1;
                end else begin
                    r_dx <= r_dx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_pixel_x     <= (sel_b ? i_job.x_b : i_job.x_a) + {14'h0, r_dx};
            o_pixel_y     <= (sel_b ? i_job.y_b : i_job.y_a) - {14'h0, r_dy};
            o_pixel_color <= sel_b ? i_job.color_b : i_job.color_a;
            o_last_write  <= last;
        end
    end

`ifndef NO_ASSERTIONS
    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && last) |=> (r_dx == 2'd0 && r_dy == 2'd0 && !r_sel))
        else $error("write counters not cleared after last write");
    a_offsets_in_zoom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_dx <= zm1 && r_dy <= zm1))
        else $error("replication offset beyond zoom");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/bmp_pixel_unpack_colorkey_scale.sv =====
// Path: a pixel-data byte passes the palette read, the key filter/queue and the output
//   register before its first write shows on the output.
// Throughput: one input item per cycle unless o_stall; one write out per cycle unless
//   i_stall, each pixel making zoom^2 writes, so that rate bounds long-run pixel rate.
// Reset (synchronous, active low) clears position, byte assembly, queue and output valid;
//   registers take their reset values; palette contents stay undefined until written.
`default_nettype none

module bmp_pixel_unpack_colorkey_scale import bpuck_pkg::*; #(
    parameter int PALETTE_ENTRIES = DEF_PALETTE_ENTRIES,
    parameter int MAX_WIDTH       = DEF_MAX_WIDTH,
    parameter int MAX_ZOOM        = DEF_MAX_ZOOM
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [7:0]  i_palette_slot,
    input  wire logic [31:0] i_palette_word,
    input  wire logic [7:0]  i_data_byte,
    // backbuffer write channel
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_pixel_x,
    output logic [15:0]      o_pixel_y,
    output logic [31:0]      o_pixel_color,
    output logic             o_last_write,
    // register write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // Register file. Writes are taken every cycle; software must write only while idle (not enforced).
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_format     <= FMT_8BPP;
            r_cfg.image_width      <= 13'd1;
            r_cfg.origin_x         <= '0;
            r_cfg.base_y           <= '0;
            r_cfg.zoom_level       <= 3'd1;
            r_cfg.key_mode         <= KEY_DRAW_ALL;
            r_cfg.key_color        <= '0;
            r_cfg.substitute_color <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_reg_idx'(i_cfg_index))
                REG_PIXEL_FORMAT:     r_cfg.pixel_format     <= i_cfg_data[1:0];
                REG_IMAGE_WIDTH:      r_cfg.image_width      <= i_cfg_data[12:0];
                REG_ORIGIN_X:         r_cfg.origin_x         <= i_cfg_data[9:0];
                REG_BASE_Y:           r_cfg.base_y           <= i_cfg_data[15:0];
                REG_ZOOM_LEVEL:       r_cfg.zoom_level       <= i_cfg_data[2:0];
                REG_KEY_MODE:         r_cfg.key_mode         <= i_cfg_data[1:0];
                REG_KEY_COLOR:        r_cfg.key_color        <= i_cfg_data;
                REG_SUBSTITUTE_COLOR: r_cfg.substitute_color <= i_cfg_data;
                default:              r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Front: accept, palette, position, key filter -> job queue
    logic     q_push, q_pop, q_full, q_empty;
    t_pix_job q_in, q_head;

    bpuck_front #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_ZOOM        (MAX_ZOOM)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_palette_slot (i_palette_slot),
        .i_palette_word (i_palette_word),
        .i_data_byte    (i_data_byte),
        .i_cfg          (r_cfg),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_job          (q_in)
    );

    // Queue decouples a stalled output from byte intake
    bpuck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // Back: zoom expansion, one transfer per cycle on the output register unless i_stall
    bpuck_back #(
        .MAX_ZOOM (MAX_ZOOM)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_empty       (q_empty),
        .i_job         (q_head),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_color (o_pixel_color),
        .o_last_write  (o_last_write)
    );

endmodule

`default_nettype wire

// ===== bench/bmp_pixel_unpack_colorkey_scale_tb.sv =====
// Self-checking bench for bmp_pixel_unpack_colorkey_scale: directed and random pixel streams
// in all four depths, checked write by write against an in-bench decoder model.
// Depends on bpuck_pkg and the block's RTL only.
`default_nettype none

module bmp_pixel_unpack_colorkey_scale_tb import bpuck_pkg::*;;

    // Caps the block applies to zoom and width (zoom also limited so two pixels fit 32 writes)
    localparam int unsigned ZOOM_CAP  = 4;
    localparam int unsigned WIDTH_CAP = 4096;
    // Opcode and key mode values outside the package enums; both act as no-ops / draw-all
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [1:0] KEY_MODE_SPARE = 2'd3;
    // Quiet cycles after the last expected write: covers pipeline depth plus skipped pixels
    localparam int SETTLE_CYCLES = 16;
    // Worst case ~410 items x 32 writes, each under the longest output stall, with a wide margin
    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  slot;
        logic [31:0] word;
        logic [7:0]  data;
    } t_item;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [31:0] color;
        logic        last;
    } t_bb_write;

    // ---------------------------------------------------------------- DUT signals
    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic [1:0]  i_opcode       = OP_START;
    logic [7:0]  i_palette_slot = 8'h00;
    logic [31:0] i_palette_word = 32'h0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [15:0] o_pixel_x;
    logic [15:0] o_pixel_y;
    logic [31:0] o_pixel_color;
    logic        o_last_write;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index    = REG_PIXEL_FORMAT;
    logic [31:0] i_cfg_data     = 32'h0;

    bmp_pixel_unpack_colorkey_scale i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_opcode       (i_opcode),
        .i_palette_slot (i_palette_slot),
        .i_palette_word (i_palette_word),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_write   (o_last_write),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- bookkeeping
    t_item     queued_items[$];   // items waiting for the driver
    t_bb_write due_writes[$];     // predicted backbuffer writes, oldest first
    int errors        = 0;
    int items_in      = 0;
    int writes_seen   = 0;
    int reg_writes    = 0;
    int setups        = 0;
    int cycles        = 0;

    // ---------------------------------------------------------------- decoder model
    // Register shadow, updated at each register transfer
    logic [1:0]  cfg_fmt       = FMT_8BPP;
    logic [12:0] cfg_width     = 13'd1;
    logic [9:0]  cfg_origin_x  = 10'd0;
    logic [15:0] cfg_base_y    = 16'd0;
    logic [2:0]  cfg_zoom      = 3'd1;
    logic [1:0]  cfg_key_mode  = KEY_DRAW_ALL;
    logic [31:0] cfg_key_color = 32'h0;
    logic [31:0] cfg_subst     = 32'h0;

    // Decoder state
    logic [31:0] pal_mem[256];
    int unsigned col_pos   = 0;
    logic [15:0] row_pos   = 16'd0;
    logic [1:0]  chan_idx  = 2'd0;    // which of B,G,R(,A) comes next
    logic [23:0] color_acc = 24'h0;

    function automatic int unsigned scale_now();
        int unsigned z;
        z = (cfg_zoom == 3'd0) ? 1 : int'(cfg_zoom);
        if (z > ZOOM_CAP) z = ZOOM_CAP;
        return z;
    endfunction

    function automatic int unsigned width_now();
        int unsigned w;
        w = (cfg_width == 13'd0) ? 1 : int'(cfg_width);
        if (w > WIDTH_CAP) w = WIDTH_CAP;
        return w;
    endfunction

    // One decoded pixel: zoom x zoom writes unless keyed out, then step the column
    task automatic emit_replicas(input logic [31:0] color);
        int unsigned z, dx, dy, xx, yy;
        logic [31:0] shade;
        t_bb_write   w;
        z = scale_now();
        shade = color;
        if (!(cfg_key_mode == KEY_SKIP && color == cfg_key_color)) begin
            if (cfg_key_mode == KEY_SUBST && color == cfg_key_color) shade = cfg_subst;
            for (dy = 0; dy < z; dy++) begin
                for (dx = 0; dx < z; dx++) begin
                    xx = cfg_origin_x + col_pos * z + dx;
                    yy = cfg_base_y - (row_pos * z + dy);  // rows climb; wraps at 16 bits
                    w.x     = xx[15:0];
                    w.y     = yy[15:0];
                    w.color = shade;
                    w.last  = 1'b0;
                    due_writes.push_back(w);
                end
            end
        end
        col_pos++;
        if (col_pos >= width_now()) begin
            col_pos = 0;
            row_pos = row_pos + 16'd1;
        end
    endtask

    task automatic decode_transfer(input logic [1:0] op, input logic [7:0] slot,
                                   input logic [31:0] word, input logic [7:0] data);
        int        before_n;
        logic [23:0] rgb;
        t_bb_write tail;
        before_n = due_writes.size();
        case (op)
            OP_START: begin
                col_pos   = 0;
                row_pos   = 16'd0;
                chan_idx  = 2'd0;
                color_acc = 24'h0;
            end
            OP_PALETTE: pal_mem[slot] = word;
            OP_PIXEL: begin
                case (cfg_fmt)
                    FMT_4BPP: begin
                        emit_replicas(pal_mem[data[7:4]]);   // high nibble first
                        emit_replicas(pal_mem[data[3:0]]);
                    end
                    FMT_8BPP: emit_replicas(pal_mem[data]);
                    FMT_24BPP: begin
                        // phase 3 left over from 32 bpp restarts at blue
                        if (chan_idx > 2'd2) chan_idx = 2'd0;
                        color_acc = color_acc | (24'(data) << (8 * chan_idx));
                        if (chan_idx == 2'd2) begin
                            rgb       = color_acc;
                            chan_idx  = 2'd0;
                            color_acc = 24'h0;
                            emit_replicas({8'h00, rgb});
                        end else begin
                            chan_idx = chan_idx + 2'd1;
                        end
                    end
                    default: begin
                        // alpha byte closes the pixel and is dropped
                        if (chan_idx == 2'd3) begin
                            rgb       = color_acc;
                            chan_idx  = 2'd0;
                            color_acc = 24'h0;
                            emit_replicas({8'h00, rgb});
                        end else begin
                            color_acc = color_acc | (24'(data) << (8 * chan_idx));
                            chan_idx  = chan_idx + 2'd1;
                        end
                    end
                endcase
            end
            default: ;
        endcase
        if (due_writes.size() > before_n) begin
            tail = due_writes.pop_back();
            tail.last = 1'b1;
            due_writes.push_back(tail);
        end
    endtask

    // ---------------------------------------------------------------- input driver
    // Bursts of back-to-back transfers separated by random gaps (zero gap = long stretch)
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : feed
        t_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (queued_items.size() != 0) begin
                nxt = queued_items.pop_front();
                i_opcode       <= nxt.op;
                i_palette_slot <= nxt.slot;
                i_palette_word <= nxt.word;
                i_data_byte    <= nxt.data;
                i_valid        <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    case ($urandom_range(0, 5))
                        0, 1:    gap_left = 0;
                        2, 3, 4: gap_left = $urandom_range(1, 4);
                        default: gap_left = $urandom_range(5, 30);
                    endcase
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Predict on every accepted input transfer (sampled before this edge's updates)
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            items_in++;
            decode_transfer(i_opcode, i_palette_slot, i_palette_word, i_data_byte);
        end
    end

    // ---------------------------------------------------------------- output side
    // Back-pressure pattern: modes of random length - none, 50%, 25%, and long holds
    int stall_mode = 0;
    int mode_left  = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin : backpressure
        logic s;
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 160);
        end
        mode_left--;
        case (stall_mode)
            0: s = 1'b0;
            1: s = 1'($urandom_range(0, 1));
            2: s = ($urandom_range(0, 3) == 0);
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    s = 1'b1;
                end else if ($urandom_range(0, 5) == 0) begin
                    hold_left = $urandom_range(0, 11);
                    s = 1'b1;
                end else begin
                    s = 1'b0;
                end
            end
        endcase
        i_stall <= s;
    end

    // Compare each accepted write with the oldest prediction
    always @(posedge i_clk) begin : check
        t_bb_write w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_writes.size() == 0) begin
                $error("unexpected write: x=%0d y=%0d color=%h last=%0b",
                       o_pixel_x, o_pixel_y, o_pixel_color, o_last_write);
                errors++;
            end else begin
                w = due_writes.pop_front();
                writes_seen++;
                if (o_pixel_x !== w.x) begin
                    $error("pixel_x: expected %0d, got %0d", w.x, o_pixel_x);
                    errors++;
                end
                if (o_pixel_y !== w.y) begin
                    $error("pixel_y: expected %0d, got %0d", w.y, o_pixel_y);
                    errors++;
                end
                if (o_pixel_color !== w.color) begin
                    $error("pixel_color: expected %h, got %h", w.color, o_pixel_color);
                    errors++;
                end
                if (o_last_write !== w.last) begin
                    $error("last_write: expected %0b, got %0b", w.last, o_last_write);
                    errors++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d writes outstanding", cycles, due_writes.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus generation
    // Generator's own view of the palette, so indexed bytes only hit written entries
    logic [31:0] gen_pal[256];
    bit          gen_written[256];
    int          written_slots[$];

    task automatic push_item(input logic [1:0] op, input logic [7:0] slot,
                             input logic [31:0] word, input logic [7:0] data);
        t_item it;
        it.op   = op;
        it.slot = slot;
        it.word = word;
        it.data = data;
        queued_items.push_back(it);
    endtask

    // Unused fields carry random junk on purpose
    task automatic push_start();
        push_item(OP_START, 8'($urandom), $urandom, 8'($urandom));
    endtask

    task automatic push_byte(input logic [7:0] b);
        push_item(OP_PIXEL, 8'($urandom), $urandom, b);
    endtask

    task automatic push_palette(input logic [7:0] slot, input logic [31:0] word);
        gen_pal[slot] = word;
        if (!gen_written[slot]) begin
            gen_written[slot] = 1'b1;
            written_slots.push_back(slot);
        end
        push_item(OP_PALETTE, slot, word, 8'($urandom));
    endtask

    function automatic logic [7:0] pick_index(input logic [7:0] key_slot);
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0) return key_slot;
        b = 8'($urandom);
        if (!gen_written[b]) b = 8'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
        return b;
    endfunction

    // ---------------------------------------------------------------- register writes
    // Caller sits at a rising edge; valid stays high across back-to-back writes
    task automatic write_reg(input t_reg_idx idx, input logic [31:0] value, input int nbits);
        logic [31:0] data;
        data = value;
        if (nbits < 32 && $urandom_range(0, 3) == 0) data = data | ($urandom << nbits);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_writes++;
        case (idx)
            REG_PIXEL_FORMAT:     cfg_fmt       = data[1:0];
            REG_IMAGE_WIDTH:      cfg_width     = data[12:0];
            REG_ORIGIN_X:         cfg_origin_x  = data[9:0];
            REG_BASE_Y:           cfg_base_y    = data[15:0];
            REG_ZOOM_LEVEL:       cfg_zoom      = data[2:0];
            REG_KEY_MODE:         cfg_key_mode  = data[1:0];
            REG_KEY_COLOR:        cfg_key_color = data;
            REG_SUBSTITUTE_COLOR: cfg_subst     = data;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [1:0] fmt, input logic [12:0] width,
                                input logic [9:0] ox, input logic [15:0] by,
                                input logic [2:0] zoom, input logic [1:0] kmode,
                                input logic [31:0] kcol, input logic [31:0] scol);
        write_reg(REG_PIXEL_FORMAT, 32'(fmt), 2);
        write_reg(REG_IMAGE_WIDTH, 32'(width), 13);
        write_reg(REG_ORIGIN_X, 32'(ox), 10);
        write_reg(REG_BASE_Y, 32'(by), 16);
        write_reg(REG_ZOOM_LEVEL, 32'(zoom), 3);
        write_reg(REG_KEY_MODE, 32'(kmode), 2);
        write_reg(REG_KEY_COLOR, kcol, 32);
        write_reg(REG_SUBSTITUTE_COLOR, scol, 32);
        i_cfg_valid <= 1'b0;
        setups++;
    endtask

    // Block idle: nothing queued or in flight, every predicted write seen, pipeline quiet
    task automatic wait_drained();
        @(posedge i_clk);
        while (queued_items.size() != 0 || i_valid || due_writes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One random setup followed by a mostly well-formed pixel stream
    task automatic random_phase(input int n_items);
        logic [1:0]  fmt;
        logic [12:0] width;
        logic [9:0]  ox;
        logic [15:0] by;
        logic [31:0] kcol, scol;
        logic [7:0]  key_slot, hi, lo;
        logic [23:0] rgb;
        int          pushed;
        fmt = 2'($urandom_range(0, 3));
        case ($urandom_range(0, 8))
            0: width = 13'd0;
            1: width = 13'd1;
            2: width = 13'd2;
            3: width = 13'd3;
            4: width = 13'd4096;
            5: width = 13'd8191;
            default: width = 13'($urandom_range(1, 40));
        endcase
        case ($urandom_range(0, 3))
            0: ox = 10'd0;
            1: ox = 10'd800;
            2: ox = 10'd1023;
            default: ox = 10'($urandom);
        endcase
        case ($urandom_range(0, 3))
            0: by = 16'd0;
            1: by = 16'hFFFF;
            2: by = 16'd5;
            default: by = 16'($urandom);
        endcase
        if (fmt == FMT_4BPP) key_slot = 8'($urandom_range(0, 15));
        else key_slot = 8'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
        if (fmt == FMT_4BPP || fmt == FMT_8BPP) kcol = gen_pal[key_slot];
        else if ($urandom_range(0, 5) == 0) kcol = $urandom;   // random alpha byte: matches only if it comes out zero
        else kcol = {8'h00, 24'($urandom)};
        case ($urandom_range(0, 3))
            0: scol = 32'h0;
            1: scol = 32'hFFFF_FFFF;
            default: scol = $urandom;
        endcase
        program_regs(fmt, width, ox, by, 3'($urandom_range(0, 7)),
                     2'($urandom_range(0, 3)), kcol, scol);
        @(negedge i_clk);

        pushed = 0;
        if ($urandom_range(0, 9) != 0) begin
            push_start();
            pushed++;
        end
        while (pushed < n_items) begin
            if ($urandom_range(0, 99) < 8) begin
                // noise: stray start, palette reload, unused opcode, lone byte
                case ($urandom_range(0, 3))
                    0: push_start();
                    1: push_palette(8'($urandom), $urandom);
                    2: push_item(OP_UNUSED, 8'($urandom), $urandom, 8'($urandom));
                    default: begin
                        // 8 bpp bytes must index a loaded entry
                        if (fmt == FMT_8BPP) push_byte(pick_index(key_slot));
                        else push_byte(8'($urandom));
                    end
                endcase
                pushed++;
            end else begin
                case (fmt)
                    FMT_4BPP: begin
                        hi = ($urandom_range(0, 3) == 0) ? key_slot : 8'($urandom);
                        lo = ($urandom_range(0, 3) == 0) ? key_slot : 8'($urandom);
                        push_byte({hi[3:0], lo[3:0]});
                        pushed++;
                    end
                    FMT_8BPP: begin
                        push_byte(pick_index(key_slot));
                        pushed++;
                    end
                    default: begin
                        rgb = ($urandom_range(0, 3) == 0) ? kcol[23:0] : 24'($urandom);
                        push_byte(rgb[7:0]);
                        push_byte(rgb[15:8]);
                        push_byte(rgb[23:16]);
                        pushed += 3;
                        if (fmt == FMT_32BPP) begin
                            push_byte(8'($urandom));
                            pushed++;
                        end
                    end
                endcase
            end
        end
    endtask

    // ---------------------------------------------------------------- test sequence
    initial begin : sequencer
        int s;
        for (s = 0; s < 256; s++) begin
            pal_mem[s]     = 32'h0;
            gen_pal[s]     = 32'h0;
            gen_written[s] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset-value registers (8 bpp, width 1, zoom 1, draw all): load the low
        // sixteen entries plus the top slot, then index the extremes
        @(negedge i_clk);
        for (s = 0; s < 16; s++) begin
            case (s)
                0:  push_palette(8'(s), 32'h0000_0000);
                9:  push_palette(8'(s), gen_pal[3]);       // duplicate color for key tests
                15: push_palette(8'(s), 32'hFFFF_FFFF);
                default: push_palette(8'(s), $urandom);
            endcase
        end
        push_palette(8'hFF, 32'hA5A5_5A5A);
        push_byte(8'h00);
        push_byte(8'h0F);
        push_byte(8'hFF);
        push_byte(8'h05);

        // 4 bpp, max zoom, skip key: both nibbles keyed, one keyed, none keyed
        wait_drained();
        program_regs(FMT_4BPP, 13'd3, 10'd1023, 16'hFFFF, 3'd4, KEY_SKIP, gen_pal[3], 32'h0);
        @(negedge i_clk);
        push_byte(8'h39);
        push_byte(8'h3A);
        push_byte(8'hF0);
        push_start();
        push_byte(8'h12);

        // 24 bpp, zoom zero, substitute key; a start lands mid-pixel
        wait_drained();
        program_regs(FMT_24BPP, 13'd2, 10'd0, 16'd0, 3'd0, KEY_SUBST, 32'h0012_3456,
                     32'hFFFF_FFFF);
        @(negedge i_clk);
        push_byte(8'h56);
        push_byte(8'h34);
        push_byte(8'h12);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'hFF);
        push_byte(8'h01);
        push_start();
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);

        // 32 bpp, zoom above cap, width zero, spare key mode; unused opcode and a
        // palette write in the middle of a pixel
        wait_drained();
        program_regs(FMT_32BPP, 13'd0, 10'd800, 16'd3, 3'd7, KEY_MODE_SPARE, 32'h0,
                     32'h1234_5678);
        @(negedge i_clk);
        push_byte(8'h11);
        push_byte(8'h22);
        push_item(OP_UNUSED, 8'h00, 32'h0, 8'hFF);
        push_palette(8'h80, 32'hFFFF_FFFF);
        push_byte(8'h33);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'h00);

        // Random setups, about 330 items in all
        for (s = 0; s < 11; s++) begin
            wait_drained();
            random_phase(30);
        end

        wait_drained();
        $display("covered %0d input transfers and %0d backbuffer writes", items_in, writes_seen);
        $display("over %0d register setups (%0d register writes), all depths and key modes",
                 setups, reg_writes);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/bpuck_pkg.sv
rtl/core/bpuck_front.sv
rtl/core/bpuck_queue.sv
rtl/core/bpuck_back.sv
rtl/core/bmp_pixel_unpack_colorkey_scale.sv
bench/bmp_pixel_unpack_colorkey_scale_tb.sv
